// File: rtl/bcts_pkg.sv
// Shared types, constants and BCD and calendar helper functions for the BCD clock time zone shift block.
package bcts_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned TzW = 11;
   localparam int unsigned MinW = 12;

   localparam logic signed [MinW-1:0] BaseOffset = 12'sd540;
   localparam logic signed [MinW-1:0] HourMinutes = 12'sd60;

   localparam logic [ByteW-1:0] HourWrap = 8'd24;
   localparam logic [ByteW-1:0] HourLast = 8'd23;
   localparam logic [ByteW-1:0] MonthWrap = 8'd13;
   localparam logic [ByteW-1:0] MonthLast = 8'd12;
   localparam logic [ByteW-1:0] MonthFeb = 8'd2;
   localparam logic [ByteW-1:0] YearLast = 8'd99;

   // Register indexes on the control port
   localparam logic CsrTimeZone = 1'b0;
   localparam logic CsrSummer = 1'b1;

   typedef struct packed {
      logic [ByteW-1:0] second_bcd;
      logic [ByteW-1:0] minute_bcd;
      logic [ByteW-1:0] hour_bcd;
      logic [ByteW-1:0] day_bcd;
      logic [ByteW-1:0] month_bcd;
      logic [ByteW-1:0] year_bcd;
   } req_type;

   typedef struct packed {
      logic [ByteW-1:0] second_out;
      logic [ByteW-1:0] minute_out;
      logic [ByteW-1:0] hour_out;
      logic [ByteW-1:0] day_out;
      logic [ByteW-1:0] month_out;
      logic [ByteW-1:0] year_out;
   } rsp_type;

   typedef struct packed {
      logic [ByteW-1:0] hour;
      logic [ByteW-1:0] day;
      logic [ByteW-1:0] month;
      logic [ByteW-1:0] year;
   } cal_type;

   // Byte-wrapping BCD to binary: b - 6*(b>>4)
   function automatic logic [ByteW-1:0] from_bcd(input logic [ByteW-1:0] b);
      logic [ByteW-1:0] hi;
      hi = {4'd0, b[7:4]};
      return b - ((hi << 2) + (hi << 1));
   endfunction

   // Byte-wrapping binary to BCD: b + 6*(b/10), b/10 as (b*205)>>11
   function automatic logic [ByteW-1:0] to_bcd(input logic [ByteW-1:0] b);
      logic [15:0] prod;
      logic [ByteW-1:0] tens;
      prod = {8'd0, b} * 16'd205;
      tens = {3'd0, prod[15:11]};
      return b + ((tens << 2) + (tens << 1));
   endfunction

   // Days in month; February gets 29 when year is a multiple of 4
   function automatic logic [ByteW-1:0] month_length(input logic [ByteW-1:0] mon,
                                                     input logic [ByteW-1:0] yr);
      logic [ByteW-1:0] len;
      case (mon)
         MonthFeb: len = (yr[1:0] == 2'd0) ? 8'd29 : 8'd28;
         8'd4, 8'd6, 8'd9, 8'd11: len = 8'd30;
         default: len = 8'd31;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/bcd_clock_timezone_shift.sv
// Top level: control registers, carry sequencer and result register of the time zone shift.
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  req_payload (bcts_pkg::req_type)
//  rsp_      out        rsp_valid/rsp_stall  rsp_payload (bcts_pkg::rsp_type)
//  csr_      in         csr_we               csr_index, csr_wdata
//
// A transaction is loaded in S_IDLE, stays in S_STEP for its N hour carries (0 to 27)
// and leaves through S_EMIT; the calendar step unit performs one hour carry per cycle.
// The block takes no new transaction until the current one reaches the result register.
// Reset is synchronous: the control registers return to 540 minutes and no summer time.
// A stalled result holds in the result register; input is not stalled by it until
// the next transaction is ready to be written out.
module bcd_clock_timezone_shift (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bcts_pkg::req_type          req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bcts_pkg::rsp_type          rsp_payload,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [bcts_pkg::TzW-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_STEP = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic signed [bcts_pkg::TzW-1:0]    tz_ff, tz_in;
   logic                               summer_ff, summer_in;
   logic signed [bcts_pkg::MinW-1:0]   min_ff, min_in;
   logic [bcts_pkg::ByteW-1:0]         sec_ff, sec_in;
   bcts_pkg::cal_type                  cal_ff, cal_in;
   bcts_pkg::cal_type                  cal_step;
   bcts_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [bcts_pkg::MinW-1:0]   shift;
   logic                               req_take;
   logic                               carry_fwd;
   logic                               carry_back;
   logic                               out_free;

   // Shared hour carry unit
   bcts_cal_step u_cal_step (
      .cal_cur   (cal_ff),
      .step_back (carry_back),
      .cal_nxt   (cal_step)
   );

   // Control registers
   always_comb begin
      tz_in     = tz_ff;
      summer_in = summer_ff;
      if (csr_we) begin
         unique case (csr_index)
            bcts_pkg::CsrTimeZone: tz_in = csr_wdata;
            bcts_pkg::CsrSummer:   summer_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Minute offset from the configured zone
   always_comb begin
      shift = {{(bcts_pkg::MinW-bcts_pkg::TzW){tz_ff[bcts_pkg::TzW-1]}}, tz_ff}
              - bcts_pkg::BaseOffset
              + (summer_ff ? bcts_pkg::HourMinutes : 12'sd0);
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign carry_fwd  = (min_ff > bcts_pkg::HourMinutes);
   assign carry_back = (min_ff < 12'sd0);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Sequencer: load, carry hours one at a time, write the result
   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      cal_in       = cal_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               sec_in       = bcts_pkg::from_bcd(req_payload.second_bcd);
               min_in       = $signed({4'd0, bcts_pkg::from_bcd(req_payload.minute_bcd)})
                              + shift;
               cal_in.hour  = bcts_pkg::from_bcd(req_payload.hour_bcd);
               cal_in.day   = bcts_pkg::from_bcd(req_payload.day_bcd);
               cal_in.month = bcts_pkg::from_bcd(req_payload.month_bcd);
               cal_in.year  = bcts_pkg::from_bcd(req_payload.year_bcd);
               state_in     = S_STEP;
            end
         end
         S_STEP: begin
            if (carry_fwd) begin
               min_in = min_ff - bcts_pkg::HourMinutes;
               cal_in = cal_step;
            end else if (carry_back) begin
               min_in = min_ff + bcts_pkg::HourMinutes;
               cal_in = cal_step;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_in.second_out = bcts_pkg::to_bcd(sec_ff);
               rsp_in.minute_out = bcts_pkg::to_bcd(min_ff[bcts_pkg::ByteW-1:0]);
               rsp_in.hour_out   = bcts_pkg::to_bcd(cal_ff.hour);
               rsp_in.day_out    = bcts_pkg::to_bcd(cal_ff.day);
               rsp_in.month_out  = bcts_pkg::to_bcd(cal_ff.month);
               rsp_in.year_out   = bcts_pkg::to_bcd(cal_ff.year);
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tz_ff        <= bcts_pkg::BaseOffset[bcts_pkg::TzW-1:0];
         summer_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tz_ff        <= tz_in;
         summer_ff    <= summer_in;
      end
   end

   // Hold the working values and the result payload
   always_ff @(posedge clock) begin
      min_ff <= min_in;
      sec_ff <= sec_in;
      cal_ff <= cal_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/bcts_cal_step.sv
// Calendar step unit: moves hour, day, month and year one hour forward or back.
module bcts_cal_step (
   input  bcts_pkg::cal_type cal_cur,
   input  logic              step_back,
   output bcts_pkg::cal_type cal_nxt
);

   logic [bcts_pkg::ByteW-1:0] hour_inc;
   logic [bcts_pkg::ByteW-1:0] day_inc;
   logic [bcts_pkg::ByteW-1:0] day_dec;
   logic [bcts_pkg::ByteW-1:0] mon_inc;
   logic [bcts_pkg::ByteW-1:0] mon_dec;
   logic [bcts_pkg::ByteW-1:0] cur_len;
   logic [bcts_pkg::ByteW-1:0] prev_mon;

   always_comb begin
      hour_inc = cal_cur.hour + 8'd1;
      day_inc  = cal_cur.day + 8'd1;
      day_dec  = cal_cur.day - 8'd1;
      mon_inc  = cal_cur.month + 8'd1;
      mon_dec  = cal_cur.month - 8'd1;
      cur_len  = bcts_pkg::month_length(cal_cur.month, cal_cur.year);
      prev_mon = (mon_dec == 8'd0) ? bcts_pkg::MonthLast : mon_dec;
   end

   always_comb begin
      cal_nxt = cal_cur;
      if (!step_back) begin
         // Advance one hour, rolling into the next day at midnight
         if (hour_inc == bcts_pkg::HourWrap) begin
            cal_nxt.hour = 8'd0;
            if (day_inc > cur_len) begin
               cal_nxt.day = 8'd1;
               if (mon_inc == bcts_pkg::MonthWrap) begin
                  cal_nxt.month = 8'd1;
                  cal_nxt.year  = (cal_cur.year == bcts_pkg::YearLast) ? 8'd0
                                                                       : cal_cur.year + 8'd1;
               end else begin
                  cal_nxt.month = mon_inc;
               end
            end else begin
               cal_nxt.day = day_inc;
            end
         end else begin
            cal_nxt.hour = hour_inc;
         end
      end else begin
         // Step back one hour, rolling into the previous day before midnight
         if (cal_cur.hour != 8'd0) begin
            cal_nxt.hour = cal_cur.hour - 8'd1;
         end else begin
            cal_nxt.hour = bcts_pkg::HourLast;
            if (day_dec == 8'd0) begin
               cal_nxt.month = prev_mon;
               if (mon_dec == 8'd0) begin
                  cal_nxt.year = (cal_cur.year == 8'd0) ? bcts_pkg::YearLast
                                                        : cal_cur.year - 8'd1;
               end
               // leap test uses the year before this step
               cal_nxt.day = bcts_pkg::month_length(prev_mon, cal_cur.year);
            end else begin
               cal_nxt.day = day_dec;
            end
         end
      end
   end

endmodule
